FILE: hdl/tqwsa_pkg.sv
// ----------------------------------------------------------------------------
// tqwsa_pkg: shared types and constants of the two-queue service arbiter
// Request and response payloads, operation and status codes, register
// indexes and the default sizes of the queues and the history ring.
// ----------------------------------------------------------------------------
package tqwsa_pkg;

  // Default sizes
  localparam int unsigned QUEUE_DEPTH_DEF   = 16;
  localparam int unsigned HISTORY_DEPTH_DEF = 16;

  // Field widths
  localparam int unsigned TAG_W     = 32;
  localparam int unsigned ACCOUNT_W = 31;
  localparam int unsigned INDEX_W   = 4;
  localparam int unsigned HCOUNT_W  = 5;
  localparam int unsigned BURST_W   = 4;
  localparam int unsigned KEEP_W    = 5;
  localparam int unsigned BCNT_W    = 5;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 5;
  localparam logic [CFG_INDEX_W-1:0] REG_REGULAR_BURST = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_HISTORY_KEEP  = 1'b1;
  localparam logic [BURST_W-1:0]     BURST_RESET       = 4'd3;
  localparam logic [KEEP_W-1:0]      KEEP_RESET        = 5'd10;
  localparam logic [BCNT_W-1:0]      BCNT_MAX          = 5'd31;

  typedef enum logic [1:0] {
    MODE_ENQ_REGULAR   = 2'd0,
    MODE_ENQ_PREFERRED = 2'd1,
    MODE_SERVE         = 2'd2,
    MODE_READ_HISTORY  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_RANGE = 2'd3
  } status_t;

  // Where the result entry of a request comes from
  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_REGULAR,
    SRC_PREFERRED,
    SRC_HISTORY
  } src_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_RETIRE
  } state_t;

  // One stored client: tag above account
  typedef struct packed {
    logic [TAG_W-1:0]     tag;
    logic [ACCOUNT_W-1:0] account;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    mode_t                mode;
    logic [TAG_W-1:0]     client_tag;
    logic [ACCOUNT_W-1:0] account;
    logic [INDEX_W-1:0]   history_index;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic                 from_preferential;
    logic [TAG_W-1:0]     out_tag;
    logic [ACCOUNT_W-1:0] out_account;
    logic [HCOUNT_W-1:0]  history_count;
  } rsp_t;

endpackage

FILE: hdl/tqwsa_chan_if.sv
// ----------------------------------------------------------------------------
// tqwsa_chan_if: valid/ready channel
// Carries one payload per handshake; a request moves when valid and ready
// are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface tqwsa_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/two_queue_weighted_service_arbiter.sv
// ----------------------------------------------------------------------------
// two_queue_weighted_service_arbiter: regular/preferential client arbiter
// Each request passes the states idle (accept), issue (access the queue or
// history memory) and retire (pick up the registered read data and
// retire); retirement waits while the output register still holds a
// response that has not been taken. The next request is taken only after
// retirement, so the block does not accept a new request while one is in
// flight. The queue and history memories have a registered read port. A
// finished response waits in an output register while the next request is
// accepted. There is no clearing pass after reset; memory slots are only
// read after they were written.
// ----------------------------------------------------------------------------
module two_queue_weighted_service_arbiter #(
  parameter int unsigned QUEUE_DEPTH   = tqwsa_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned HISTORY_DEPTH = tqwsa_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tqwsa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tqwsa_pkg::CFG_DATA_W-1:0]  cfg_data,
  tqwsa_chan_if.sink                        req,
  tqwsa_chan_if.source                      rsp
);

  localparam int unsigned QIW = $clog2(QUEUE_DEPTH);
  localparam int unsigned HIW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  logic              q_we;
  logic [QIW:0]      q_waddr;
  tqwsa_pkg::entry_t q_wdata;
  logic              q_re;
  logic [QIW:0]      q_raddr;
  tqwsa_pkg::entry_t q_rdata;
  logic              h_we;
  logic [HIW-1:0]    h_waddr;
  tqwsa_pkg::entry_t h_wdata;
  logic              h_re;
  logic [HIW-1:0]    h_raddr;
  tqwsa_pkg::entry_t h_rdata;

  // Sequencer
  tqwsa_ctrl #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp),
    .q_we      (q_we),
    .q_waddr   (q_waddr),
    .q_wdata   (q_wdata),
    .q_re      (q_re),
    .q_raddr   (q_raddr),
    .q_rdata   (q_rdata),
    .h_we      (h_we),
    .h_waddr   (h_waddr),
    .h_wdata   (h_wdata),
    .h_re      (h_re),
    .h_raddr   (h_raddr),
    .h_rdata   (h_rdata)
  );

  // Both client queues share one memory, split by the top address bit
  tqwsa_ram #(
    .AW (QIW + 1),
    .DW (tqwsa_pkg::ENTRY_W)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // History ring
  tqwsa_ram #(
    .AW (HIW),
    .DW (tqwsa_pkg::ENTRY_W)
  ) u_history_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (h_re),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

endmodule

FILE: hdl/tqwsa_ram.sv
// ----------------------------------------------------------------------------
// tqwsa_ram: single-port-write, single-port-read synchronous memory
// One write and one read per cycle; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module tqwsa_ram #(
  parameter int unsigned AW = 4,
  parameter int unsigned DW = 63
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [1 << AW];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/tqwsa_ctrl.sv
// ----------------------------------------------------------------------------
// tqwsa_ctrl: request sequencer of the two-queue service arbiter
// Holds the queue and history pointers, the burst counter and the
// configuration, issues memory accesses and retires one response per request.
// ----------------------------------------------------------------------------
module tqwsa_ctrl #(
  parameter int unsigned QUEUE_DEPTH   = tqwsa_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned HISTORY_DEPTH = tqwsa_pkg::HISTORY_DEPTH_DEF,
  localparam int unsigned QIW = $clog2(QUEUE_DEPTH),
  localparam int unsigned HIW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [tqwsa_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [tqwsa_pkg::CFG_DATA_W-1:0]       cfg_data,
  tqwsa_chan_if.sink                             req,
  tqwsa_chan_if.source                           rsp,
  // Queue memory: {queue select, slot}
  output logic                                   q_we,
  output logic [QIW:0]                           q_waddr,
  output tqwsa_pkg::entry_t                      q_wdata,
  output logic                                   q_re,
  output logic [QIW:0]                           q_raddr,
  input  tqwsa_pkg::entry_t                      q_rdata,
  // History memory
  output logic                                   h_we,
  output logic [HIW-1:0]                         h_waddr,
  output tqwsa_pkg::entry_t                      h_wdata,
  output logic                                   h_re,
  output logic [HIW-1:0]                         h_raddr,
  input  tqwsa_pkg::entry_t                      h_rdata
);

  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QSW = QCW + 1;
  localparam int unsigned HCW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned HSW = HCW + 1;
  localparam int unsigned HXW = ((HCW > tqwsa_pkg::INDEX_W) ? HCW : tqwsa_pkg::INDEX_W) + 1;
  localparam logic Q_REGULAR   = 1'b0;
  localparam logic Q_PREFERRED = 1'b1;

  tqwsa_pkg::state_t  state;
  tqwsa_pkg::state_t  state_next;
  tqwsa_pkg::req_t    req_q;
  tqwsa_pkg::status_t res_status;
  tqwsa_pkg::src_t    res_src;
  tqwsa_pkg::rsp_t    rsp_q;
  tqwsa_pkg::rsp_t    rsp_next;
  logic               rsp_valid;

  logic [tqwsa_pkg::BURST_W-1:0] regular_burst;
  logic [tqwsa_pkg::KEEP_W-1:0]  history_keep;
  logic [tqwsa_pkg::BCNT_W-1:0]  burst_counter;
  logic [QIW-1:0]                reg_head;
  logic [QCW-1:0]                reg_count;
  logic [QIW-1:0]                pref_head;
  logic [QCW-1:0]                pref_count;
  logic [HIW-1:0]                hist_head;
  logic [HCW-1:0]                hist_fill;
  logic [HIW-1:0]                hist_head_next;
  logic [HCW-1:0]                hist_fill_next;

  logic accept;
  logic issue_en;
  logic retire_en;
  logic slot_free;

  // Issue-stage decode
  logic                         is_enq;
  logic                         enq_regular;
  logic [QIW-1:0]               enq_head;
  logic [QCW-1:0]               enq_count;
  logic                         enq_full;
  logic [QSW-1:0]               tail_sum;
  logic [QSW-1:0]               tail_wrap;
  logic [tqwsa_pkg::BCNT_W-1:0] bc_inc;
  logic                         take_reg;
  logic                         take_pref;
  logic [QIW-1:0]               reg_head_inc;
  logic [QIW-1:0]               pref_head_inc;
  logic                         idx_ok;
  logic [HXW-1:0]               hrd_sum;
  logic [HXW-1:0]               hrd_wrap;

  // Retire-stage history update
  tqwsa_pkg::entry_t entry;
  logic              append;
  logic [HSW-1:0]    hw_sum;
  logic [HSW-1:0]    hw_wrap;
  logic              fill_full;
  logic [HIW-1:0]    head_inc;
  logic [HCW-1:0]    fill1;
  logic [HIW-1:0]    head1;
  logic              keep_over;
  logic [HCW-1:0]    keep_eff;
  logic              trim;
  logic [HCW-1:0]    drop;
  logic [HSW-1:0]    h2_sum;
  logic [HSW-1:0]    h2_wrap;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tqwsa_pkg::ST_IDLE: begin
        if (req.valid) begin
          state_next = tqwsa_pkg::ST_ISSUE;
        end
      end
      tqwsa_pkg::ST_ISSUE: begin
        state_next = tqwsa_pkg::ST_RETIRE;
      end
      tqwsa_pkg::ST_RETIRE: begin
        if (slot_free) begin
          state_next = tqwsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tqwsa_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    req.ready = 1'b0;
    issue_en  = 1'b0;
    retire_en = 1'b0;
    unique case (state)
      tqwsa_pkg::ST_IDLE:   req.ready = 1'b1;
      tqwsa_pkg::ST_ISSUE:  issue_en  = 1'b1;
      tqwsa_pkg::ST_RETIRE: retire_en = slot_free;
      default: begin
      end
    endcase
  end

  assign accept    = req.valid && req.ready;
  assign slot_free = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tqwsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req.payload;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regular_burst <= tqwsa_pkg::BURST_RESET;
      history_keep  <= tqwsa_pkg::KEEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tqwsa_pkg::REG_REGULAR_BURST: regular_burst <= cfg_data[tqwsa_pkg::BURST_W-1:0];
        tqwsa_pkg::REG_HISTORY_KEEP:  history_keep  <= cfg_data[tqwsa_pkg::KEEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Issue: enqueue slot and full check
  assign is_enq      = (req_q.mode == tqwsa_pkg::MODE_ENQ_REGULAR) ||
                       (req_q.mode == tqwsa_pkg::MODE_ENQ_PREFERRED);
  assign enq_regular = (req_q.mode == tqwsa_pkg::MODE_ENQ_REGULAR);
  assign enq_head    = enq_regular ? reg_head : pref_head;
  assign enq_count   = enq_regular ? reg_count : pref_count;
  assign enq_full    = (enq_count == QCW'(QUEUE_DEPTH));
  assign tail_sum    = QSW'(enq_head) + QSW'(enq_count);
  assign tail_wrap   = (tail_sum >= QSW'(QUEUE_DEPTH)) ? tail_sum - QSW'(QUEUE_DEPTH) : tail_sum;

  // Issue: serve decision, burst counter saturates
  assign bc_inc    = (burst_counter != tqwsa_pkg::BCNT_MAX) ? burst_counter + 1'b1
                                                            : burst_counter;
  assign take_reg  = (bc_inc <= {1'b0, regular_burst}) && (reg_count != '0);
  assign take_pref = !take_reg && (pref_count != '0);
  assign reg_head_inc  = (reg_head == QIW'(QUEUE_DEPTH - 1)) ? '0 : reg_head + 1'b1;
  assign pref_head_inc = (pref_head == QIW'(QUEUE_DEPTH - 1)) ? '0 : pref_head + 1'b1;

  // Issue: history read address
  assign idx_ok   = HXW'(req_q.history_index) < HXW'(hist_fill);
  assign hrd_sum  = HXW'(hist_head) + HXW'(req_q.history_index);
  assign hrd_wrap = (hrd_sum >= HXW'(HISTORY_DEPTH)) ? hrd_sum - HXW'(HISTORY_DEPTH) : hrd_sum;

  // Memory accesses of the issue cycle; each request finishes its writes
  // before the next one reads, so no forwarding is needed
  assign q_we    = issue_en && is_enq && !enq_full;
  assign q_waddr = {enq_regular ? Q_REGULAR : Q_PREFERRED, tail_wrap[QIW-1:0]};
  assign q_wdata = '{tag: req_q.client_tag, account: req_q.account};
  assign q_re    = issue_en && (req_q.mode == tqwsa_pkg::MODE_SERVE) && (take_reg || take_pref);
  assign q_raddr = take_reg ? {Q_REGULAR, reg_head} : {Q_PREFERRED, pref_head};
  assign h_re    = issue_en && (req_q.mode == tqwsa_pkg::MODE_READ_HISTORY) && idx_ok;
  assign h_raddr = hrd_wrap[HIW-1:0];

  // Issue: update queue pointers and the burst counter
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_head      <= '0;
      reg_count     <= '0;
      pref_head     <= '0;
      pref_count    <= '0;
      burst_counter <= '0;
    end else if (issue_en) begin
      case (req_q.mode)
        tqwsa_pkg::MODE_ENQ_REGULAR: begin
          if (!enq_full) begin
            reg_count <= reg_count + 1'b1;
          end
        end
        tqwsa_pkg::MODE_ENQ_PREFERRED: begin
          if (!enq_full) begin
            pref_count <= pref_count + 1'b1;
          end
        end
        tqwsa_pkg::MODE_SERVE: begin
          if (take_reg) begin
            reg_head      <= reg_head_inc;
            reg_count     <= reg_count - 1'b1;
            burst_counter <= bc_inc;
          end else begin
            burst_counter <= '0;
            if (take_pref) begin
              pref_head  <= pref_head_inc;
              pref_count <= pref_count - 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Issue: record outcome for the retire cycle
  always_ff @(posedge clk) begin
    if (issue_en) begin
      res_status <= tqwsa_pkg::STATUS_OK;
      res_src    <= tqwsa_pkg::SRC_NONE;
      case (req_q.mode)
        tqwsa_pkg::MODE_ENQ_REGULAR, tqwsa_pkg::MODE_ENQ_PREFERRED: begin
          if (enq_full) begin
            res_status <= tqwsa_pkg::STATUS_FULL;
          end
        end
        tqwsa_pkg::MODE_SERVE: begin
          if (take_reg) begin
            res_src <= tqwsa_pkg::SRC_REGULAR;
          end else if (take_pref) begin
            res_src <= tqwsa_pkg::SRC_PREFERRED;
          end else begin
            res_status <= tqwsa_pkg::STATUS_EMPTY;
          end
        end
        default: begin
          if (idx_ok) begin
            res_src <= tqwsa_pkg::SRC_HISTORY;
          end else begin
            res_status <= tqwsa_pkg::STATUS_RANGE;
          end
        end
      endcase
    end
  end

  // Retire: append the served client and trim to the keep limit
  assign entry     = (res_src == tqwsa_pkg::SRC_HISTORY) ? h_rdata : q_rdata;
  assign append    = (res_src == tqwsa_pkg::SRC_REGULAR) || (res_src == tqwsa_pkg::SRC_PREFERRED);
  assign hw_sum    = HSW'(hist_head) + HSW'(hist_fill);
  assign hw_wrap   = (hw_sum >= HSW'(HISTORY_DEPTH)) ? hw_sum - HSW'(HISTORY_DEPTH) : hw_sum;
  assign fill_full = (hist_fill == HCW'(HISTORY_DEPTH));
  assign head_inc  = (hist_head == HIW'(HISTORY_DEPTH - 1)) ? '0 : hist_head + 1'b1;
  assign fill1     = fill_full ? hist_fill : hist_fill + 1'b1;
  assign head1     = fill_full ? head_inc : hist_head;
  assign keep_over = {3'b000, history_keep} > 8'(HISTORY_DEPTH);
  assign keep_eff  = keep_over ? HCW'(HISTORY_DEPTH) : HCW'(history_keep);
  assign trim      = fill1 > keep_eff;
  assign drop      = trim ? fill1 - keep_eff : '0;
  assign h2_sum    = HSW'(head1) + HSW'(drop);
  assign h2_wrap   = (h2_sum >= HSW'(HISTORY_DEPTH)) ? h2_sum - HSW'(HISTORY_DEPTH) : h2_sum;

  assign hist_head_next = append ? h2_wrap[HIW-1:0] : hist_head;
  assign hist_fill_next = append ? (trim ? keep_eff : fill1) : hist_fill;

  assign h_we    = retire_en && append;
  assign h_waddr = hw_wrap[HIW-1:0];
  assign h_wdata = q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_head <= '0;
      hist_fill <= '0;
    end else if (retire_en) begin
      hist_head <= hist_head_next;
      hist_fill <= hist_fill_next;
    end
  end

  // Retire: build the response
  always_comb begin
    rsp_next                   = '0;
    rsp_next.status            = res_status;
    rsp_next.from_preferential = (res_src == tqwsa_pkg::SRC_PREFERRED);
    rsp_next.history_count     = tqwsa_pkg::HCOUNT_W'(hist_fill_next);
    if (res_src != tqwsa_pkg::SRC_NONE) begin
      rsp_next.out_tag     = entry.tag;
      rsp_next.out_account = entry.account;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (retire_en) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (retire_en) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_q;

  // A retired request shows up at the output
  a_retire_shows: assert property (@(posedge clk) disable iff (rst)
    retire_en |=> rsp_valid)
    else $error("retired request not presented");

  // Queue memory is never written and read in the same cycle
  a_qmem_excl: assert property (@(posedge clk) disable iff (rst)
    !(q_we && q_re))
    else $error("queue memory write and read overlap");

  // A serve that skips the regular queue clears the burst counter
  a_burst_clear: assert property (@(posedge clk) disable iff (rst)
    (issue_en && (req_q.mode == tqwsa_pkg::MODE_SERVE) && !take_reg) |=>
    (burst_counter == '0))
    else $error("burst counter not cleared");

  // After an append the history holds no more than the keep limit
  a_hist_keep: assert property (@(posedge clk) disable iff (rst)
    (retire_en && append) |=> (hist_fill <= keep_eff))
    else $error("history exceeds keep limit");

endmodule

FILE: verif/tqwsa_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tqwsa_checker: response checker for the two-queue service arbiter
// Watches the register port and both channels, keeps its own copy of the
// two client FIFOs, the service history and the burst counter, predicts the
// response of every accepted request and compares each accepted response,
// field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tqwsa_checker
  import tqwsa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  tqwsa_chan_if                  req_mon,
  tqwsa_chan_if                  rsp_mon,
  output int                     failures,
  output int                     outstanding
);

  // Register copies and predicted state
  logic [BURST_W-1:0] burst_limit;
  logic [KEEP_W-1:0]  keep_limit;
  logic [BCNT_W-1:0]  burst_run;
  entry_t             regular_q[$];
  entry_t             preferred_q[$];
  entry_t             served_log[$];
  rsp_t               awaited_responses[$];

  int fail_cnt    = 0;
  int waiting_cnt = 0;

  assign failures    = fail_cnt;
  assign outstanding = waiting_cnt;

  // Append a served client, drop the oldest beyond the ring and the keep limit
  function automatic void log_served(input entry_t e);
    int unsigned cap;
    cap = (keep_limit > HISTORY_DEPTH_DEF) ? HISTORY_DEPTH_DEF : keep_limit;
    if (served_log.size() >= HISTORY_DEPTH_DEF) void'(served_log.pop_front());
    served_log.push_back(e);
    while (served_log.size() > cap) void'(served_log.pop_front());
  endfunction

  // Work out the response to one request and advance the state
  function automatic rsp_t predict_response(input req_t r);
    rsp_t   res;
    entry_t e;
    res = '0;
    e.tag = r.client_tag;
    e.account = r.account;
    case (r.mode)
      MODE_ENQ_REGULAR: begin
        if (regular_q.size() >= QUEUE_DEPTH_DEF) res.status = STATUS_FULL;
        else regular_q.push_back(e);
      end
      MODE_ENQ_PREFERRED: begin
        if (preferred_q.size() >= QUEUE_DEPTH_DEF) res.status = STATUS_FULL;
        else preferred_q.push_back(e);
      end
      MODE_SERVE: begin
        if (burst_run != BCNT_MAX) burst_run = burst_run + 1'b1;
        if (burst_run <= burst_limit && regular_q.size() != 0) begin
          e = regular_q.pop_front();
          res.out_tag = e.tag;
          res.out_account = e.account;
          log_served(e);
        end else begin
          if (preferred_q.size() != 0) begin
            e = preferred_q.pop_front();
            res.from_preferential = 1'b1;
            res.out_tag = e.tag;
            res.out_account = e.account;
            log_served(e);
          end else begin
            res.status = STATUS_EMPTY;
          end
          burst_run = '0;
        end
      end
      default: begin
        if (r.history_index < served_log.size()) begin
          e = served_log[r.history_index];
          res.out_tag = e.tag;
          res.out_account = e.account;
        end else begin
          res.status = STATUS_RANGE;
        end
      end
    endcase
    res.history_count = HCOUNT_W'(served_log.size());
    return res;
  endfunction

  // Track register writes, predict on each request, compare each response
  always @(posedge clk) begin : watch
    rsp_t want;
    rsp_t got;
    if (rst) begin
      burst_limit = BURST_RESET;
      keep_limit = KEEP_RESET;
      burst_run = '0;
      regular_q.delete();
      preferred_q.delete();
      served_log.delete();
      awaited_responses.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_REGULAR_BURST) burst_limit = cfg_data[BURST_W-1:0];
        else if (cfg_index == REG_HISTORY_KEEP) keep_limit = cfg_data[KEEP_W-1:0];
      end
      if (req_mon.valid && req_mon.ready)
        awaited_responses.push_back(predict_response(req_mon.payload));
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = rsp_mon.payload;
        if (awaited_responses.size() == 0) begin
          $error("response with no request waiting: %h", got);
          fail_cnt = fail_cnt + 1;
        end else begin
          want = awaited_responses.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_cnt = fail_cnt + 1;
          end
          if (got.from_preferential !== want.from_preferential) begin
            $error("from_preferential: expected %0d, got %0d",
                   want.from_preferential, got.from_preferential);
            fail_cnt = fail_cnt + 1;
          end
          if (got.out_tag !== want.out_tag) begin
            $error("out_tag: expected %h, got %h", want.out_tag, got.out_tag);
            fail_cnt = fail_cnt + 1;
          end
          if (got.out_account !== want.out_account) begin
            $error("out_account: expected %h, got %h", want.out_account, got.out_account);
            fail_cnt = fail_cnt + 1;
          end
          if (got.history_count !== want.history_count) begin
            $error("history_count: expected %0d, got %0d",
                   want.history_count, got.history_count);
            fail_cnt = fail_cnt + 1;
          end
        end
      end
    end
    waiting_cnt <= awaited_responses.size();
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level for the two-queue service arbiter
// Drives a short directed sequence and then phases of random requests,
// each phase under its own register settings and one of three idle patterns
// on both channels, with one long response hold-off and one drain inside a phase. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import tqwsa_pkg::*;

  localparam int PHASES          = 8;
  localparam int PHASE_REQUESTS  = 200;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int TIMEOUT_NS      = 5_000_000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     failures;
  int                     outstanding;

  // Idle rates in percent and long hold-off requests to the receiver
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_offs_asked = 0;
  int hold_offs_done  = 0;

  // Per-phase register settings and enqueue share in percent
  int phase_burst[PHASES]   = '{3, 0, 15, 1, 15, 7, 2, 5};
  int phase_keep[PHASES]    = '{10, 0, 31, 16, 2, 1, 16, 5};
  int phase_enq_pct[PHASES] = '{50, 40, 65, 45, 55, 35, 50, 45};

  tqwsa_chan_if #(.payload_t(req_t)) req_ch ();
  tqwsa_chan_if #(.payload_t(rsp_t)) rsp_ch ();

  two_queue_weighted_service_arbiter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  tqwsa_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_mon     (req_ch),
    .rsp_mon     (rsp_ch),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Build one request
  function automatic req_t make_request(input mode_t m, input logic [TAG_W-1:0] tag,
                                        input logic [ACCOUNT_W-1:0] acct,
                                        input logic [INDEX_W-1:0] idx);
    req_t r;
    r.mode = m;
    r.client_tag = tag;
    r.account = acct;
    r.history_index = idx;
    return r;
  endfunction

  // Random request: enqueue share given, rest mostly serves, some reads
  function automatic req_t random_request(input int enq_pct);
    int    pick;
    mode_t m;
    pick = $urandom_range(99);
    if (pick < enq_pct)
      m = ($urandom_range(2) == 0) ? MODE_ENQ_PREFERRED : MODE_ENQ_REGULAR;
    else if (pick < enq_pct + (100 - enq_pct) * 3 / 4)
      m = MODE_SERVE;
    else
      m = MODE_READ_HISTORY;
    return make_request(m, TAG_W'($urandom), ACCOUNT_W'($urandom),
                        INDEX_W'($urandom_range(15)));
  endfunction

  // Offer one request after a random gap and hold it until accepted
  task automatic issue_request(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.payload <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait until no response is outstanding
  task automatic wait_until_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write both registers on consecutive edges; the block must be idle
  task automatic apply_settings(input int burst, input int keep);
    cfg_we <= 1'b1;
    cfg_index <= REG_REGULAR_BURST;
    cfg_data <= CFG_DATA_W'(burst);
    @(posedge clk);
    cfg_index <= REG_HISTORY_KEEP;
    cfg_data <= CFG_DATA_W'(keep);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Response side: random stalls, and a counted hold-off when one is asked
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_offs_done != hold_offs_asked) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_offs_done = hold_offs_done + 1;
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Request side and verdict
  initial begin
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty serve, empty history read, field extremes, burst handover
    issue_request(make_request(MODE_SERVE, '0, '0, '0));
    issue_request(make_request(MODE_READ_HISTORY, '0, '0, '0));
    issue_request(make_request(MODE_ENQ_REGULAR, '0, '0, '0));
    issue_request(make_request(MODE_ENQ_REGULAR, '1, '1, '1));
    issue_request(make_request(MODE_ENQ_PREFERRED, 32'hA5A5_5A5A, 31'h2AAA_5555, '0));
    issue_request(make_request(MODE_SERVE, '1, '1, '1));
    issue_request(make_request(MODE_SERVE, '0, '0, '0));
    issue_request(make_request(MODE_SERVE, '0, '0, '0));
    issue_request(make_request(MODE_READ_HISTORY, '0, '0, '0));
    issue_request(make_request(MODE_READ_HISTORY, '0, '0, '1));
    // Fill the regular queue and push once more into the full queue
    for (int i = 0; i <= QUEUE_DEPTH_DEF; i++)
      issue_request(make_request(MODE_ENQ_REGULAR, TAG_W'(i), ACCOUNT_W'(i * 7), '0));

    // Random phases under changing settings and idle patterns
    for (int p = 0; p < PHASES; p++) begin
      wait_until_drained();
      apply_settings(phase_burst[p], phase_keep[p]);
      if (p < 3) begin
        send_idle_pct = 19;
        recv_idle_pct = 55;
      end else if (p < 6) begin
        send_idle_pct = 55;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if (p == 1 && n == 60) hold_offs_asked = hold_offs_asked + 1;
        if (p == 4 && n == 100) wait_until_drained();
        issue_request(random_request(phase_enq_pct[p]));
      end
    end

    wait_until_drained();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin
    #TIMEOUT_NS;
    $display("testbench failed");
    $finish;
  end

endmodule
